[rtl/meq_pkg.sv]
// ----------------------------------------------------------------------------
// Motion event qualifier package
// Shared types, codes and constants for the motion event qualifier.
// ----------------------------------------------------------------------------
package meq_pkg;

  localparam int unsigned RoiWidth       = 52;
  localparam int unsigned DefRegionCount = 52;
  localparam int unsigned SecWidth       = 12;
  localparam int unsigned DebWidth       = 8;
  localparam int unsigned CfgIdxWidth    = 3;
  localparam int unsigned CfgDataWidth   = 12;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [SecWidth-1:0] SecMax = '1;
  localparam logic [DebWidth-1:0] DebMax = '1;

  typedef enum logic {
    KindTick  = 1'b0,
    KindFrame = 1'b1
  } meq_kind_e;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvStart = 2'd1,
    EvStop  = 2'd2
  } meq_event_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgInit     = 3'd0,
    CfgCooldown = 3'd1,
    CfgDebounce = 3'd2,
    CfgMin      = 3'd3,
    CfgPost     = 3'd4,
    CfgHome     = 3'd5,
    CfgAutoHome = 3'd6
  } meq_cfg_e;

  typedef struct packed {
    meq_kind_e kind;
    logic      hit;
  } meq_item_t;

  function automatic logic [SecWidth-1:0] sat_inc(input logic [SecWidth-1:0] v);
    sat_inc = (v == SecMax) ? SecMax : v + 1'b1;
  endfunction

endpackage

[rtl/motion_event_qualifier.sv]
// ----------------------------------------------------------------------------
// Motion event qualifier
// Turns one-second ticks and per-frame motion results into motion start,
// motion stop and auto-home items.
// ----------------------------------------------------------------------------
// Usage: each input item is a tick (kind 0) or a frame result (kind 1) with
// its region-hit mask. Every frame yields one result item; a tick yields a
// result item only when it fires the auto-home request.
// Both channels use valid/ready. An input item enters a two-entry queue in
// the cycle it is accepted. The state update takes it from the queue once the
// result register is empty or being taken, and also loads the result register,
// from which the result item is offered.
// One item is taken per cycle while the receiver keeps taking result items.
// When the receiver stalls, the result register holds its item, the state
// update waits, the queue fills and input ready drops once two items wait.
// Configuration must be written via cfg_we_i, cfg_idx_i and cfg_data_i only
// while the block is idle; the block does not enforce this. Reset zeroes the
// configuration, empties queue and result register, starts the initial period.
// ----------------------------------------------------------------------------
module motion_event_qualifier #(
  parameter int unsigned REGION_COUNT = meq_pkg::DefRegionCount
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [meq_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [meq_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic [meq_pkg::RoiWidth-1:0]     roi_mask_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       event_res_o,
  output logic                             go_home_o,
  output logic                             active_o,
  output logic                             skipped_o
);
  import meq_pkg::*;

  meq_item_t front_item, queue_item;
  logic      queue_full, queue_empty, push, pop;

  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && in_ready_o;

  meq_front #(
    .REGION_COUNT(REGION_COUNT)
  ) u_front (
    .kind_i     (kind_i),
    .roi_mask_i (roi_mask_i),
    .item_o     (front_item)
  );

  meq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .empty_o     (queue_empty),
    .pop_item_o  (queue_item)
  );

  meq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .empty_i     (queue_empty),
    .item_i      (queue_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_res_o (event_res_o),
    .go_home_o   (go_home_o),
    .active_o    (active_o),
    .skipped_o   (skipped_o)
  );

  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EvStart) |-> active_o)
    else $error("Start item without active motion.");

  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EvStop) |-> !active_o)
    else $error("Stop item while motion still active.");

  a_skip_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && skipped_o |-> (event_res_o == EvNone))
    else $error("Skipped frame carries an event.");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_full && !pop |=> !$past(push))
    else $error("Item pushed into a full queue.");

endmodule

[rtl/meq_front.sv]
// ----------------------------------------------------------------------------
// Motion event qualifier front end
// Classifies an incoming item as tick or frame and reduces the region mask.
// ----------------------------------------------------------------------------
module meq_front #(
  parameter int unsigned REGION_COUNT = meq_pkg::DefRegionCount
) (
  input  logic                         kind_i,
  input  logic [meq_pkg::RoiWidth-1:0] roi_mask_i,
  output meq_pkg::meq_item_t           item_o
);
  import meq_pkg::*;

  logic [RoiWidth-1:0] region_mask;

  always_comb begin
    for (int i = 0; i < RoiWidth; i++) begin
      region_mask[i] = (i < REGION_COUNT);
    end
  end

  assign item_o.kind = meq_kind_e'(kind_i);
  assign item_o.hit  = |(roi_mask_i & region_mask);

endmodule

[rtl/meq_queue.sv]
// ----------------------------------------------------------------------------
// Motion event qualifier queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module meq_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  meq_pkg::meq_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output meq_pkg::meq_item_t pop_item_o
);
  import meq_pkg::*;

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  meq_item_t             mem_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   count_q, count_d;

  assign full_o     = (count_q == CntWidth'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/meq_back.sv]
// ----------------------------------------------------------------------------
// Motion event qualifier back end
// Holds the configuration and motion state, updates the motion state for each
// item and drives the registered result.
// ----------------------------------------------------------------------------
module meq_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [meq_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [meq_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                             empty_i,
  input  meq_pkg::meq_item_t               item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       event_res_o,
  output logic                             go_home_o,
  output logic                             active_o,
  output logic                             skipped_o
);
  import meq_pkg::*;

  logic [SecWidth-1:0] init_sec_q, cool_sec_q, min_sec_q, post_sec_q, home_sec_q;
  logic [DebWidth-1:0] deb_frames_q;
  logic                auto_home_q;

  logic                initial_phase_q, initial_phase_d;
  logic                cooling_q, cooling_d;
  logic                moving_q, moving_d;
  logic                home_pending_q, home_pending_d;
  logic [SecWidth-1:0] since_start_q, since_start_d;
  logic [SecWidth-1:0] since_cool_q, since_cool_d;
  logic [SecWidth-1:0] since_motion_q, since_motion_d;
  logic [SecWidth-1:0] since_stop_q, since_stop_d;
  logic [DebWidth-1:0] deb_count_q, deb_count_d;

  meq_event_e          ev;
  logic                skip, home, produce;

  logic                out_valid_q, out_valid_d;
  logic [1:0]          event_res_q;
  logic                go_home_q, active_q, skipped_q;

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_sec_q   <= '0;
      cool_sec_q   <= '0;
      deb_frames_q <= '0;
      min_sec_q    <= '0;
      post_sec_q   <= '0;
      home_sec_q   <= '0;
      auto_home_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgInit:     init_sec_q   <= cfg_data_i[SecWidth-1:0];
        CfgCooldown: cool_sec_q   <= cfg_data_i[SecWidth-1:0];
        CfgDebounce: deb_frames_q <= cfg_data_i[DebWidth-1:0];
        CfgMin:      min_sec_q    <= cfg_data_i[SecWidth-1:0];
        CfgPost:     post_sec_q   <= cfg_data_i[SecWidth-1:0];
        CfgHome:     home_sec_q   <= cfg_data_i[SecWidth-1:0];
        CfgAutoHome: auto_home_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    initial_phase_d = initial_phase_q;
    cooling_d       = cooling_q;
    moving_d        = moving_q;
    home_pending_d  = home_pending_q;
    since_start_d   = since_start_q;
    since_cool_d    = since_cool_q;
    since_motion_d  = since_motion_q;
    since_stop_d    = since_stop_q;
    deb_count_d     = deb_count_q;
    ev              = EvNone;
    skip            = 1'b0;
    home            = 1'b0;

    if (item_i.kind == KindTick) begin
      since_start_d  = sat_inc(since_start_q);
      since_cool_d   = sat_inc(since_cool_q);
      since_motion_d = sat_inc(since_motion_q);
      since_stop_d   = sat_inc(since_stop_q);
    end else begin
      if (initial_phase_q && (since_start_q < init_sec_q)) begin
        skip = 1'b1;
      end else begin
        initial_phase_d = 1'b0;
        if (cooling_q && (since_cool_q < cool_sec_q)) begin
          skip = 1'b1;
        end else begin
          cooling_d = 1'b0;
        end
      end
      if (!skip) begin
        if (item_i.hit) begin
          if (deb_count_q >= deb_frames_q) begin
            if (!moving_q) begin
              moving_d = 1'b1;
              ev       = EvStart;
            end
            since_motion_d = '0;
          end
          if (deb_count_q != DebMax) begin
            deb_count_d = deb_count_q + 1'b1;
          end
        end else begin
          deb_count_d = '0;
          if (moving_q && (since_motion_q >= min_sec_q) && (since_motion_q >= post_sec_q)) begin
            ev           = EvStop;
            moving_d     = 1'b0;
            cooling_d    = 1'b1;
            since_cool_d = '0;
            if (auto_home_q) begin
              home_pending_d = 1'b1;
              since_stop_d   = '0;
            end
          end
        end
      end
    end

    if (auto_home_q && home_pending_d && (since_stop_d >= home_sec_q)) begin
      home           = 1'b1;
      home_pending_d = 1'b0;
    end
  end

  assign produce = (item_i.kind == KindFrame) || home;

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = produce;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_phase_q <= 1'b1;
      cooling_q       <= 1'b0;
      moving_q        <= 1'b0;
      home_pending_q  <= 1'b0;
      since_start_q   <= '0;
      since_cool_q    <= '0;
      since_motion_q  <= '0;
      since_stop_q    <= '0;
      deb_count_q     <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        initial_phase_q <= initial_phase_d;
        cooling_q       <= cooling_d;
        moving_q        <= moving_d;
        home_pending_q  <= home_pending_d;
        since_start_q   <= since_start_d;
        since_cool_q    <= since_cool_d;
        since_motion_q  <= since_motion_d;
        since_stop_q    <= since_stop_d;
        deb_count_q     <= deb_count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && produce) begin
      event_res_q <= ev;
      go_home_q   <= home;
      active_q    <= moving_d;
      skipped_q   <= skip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_res_q;
  assign go_home_o   = go_home_q;
  assign active_o    = active_q;
  assign skipped_o   = skipped_q;

endmodule
